@@ rtl/sicr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sicr_pkg
// Shared types and constants of the integral current regulator: item
// layouts, register indexes and the fixed-point sizing of the integrator.
// ----------------------------------------------------------------------------
package sicr_pkg;

   // Fixed-point format and PWM sizing
   localparam int FRAC_BITS  = 8;
   localparam int PWM_PERIOD = 512;
   localparam int MAX_DRIVE  = 1024;
   localparam int GAIN_SHIFT = 2;   // integral gain of 4

   localparam int ADC_W   = 16;
   localparam int DUTY_W  = 10;
   localparam int CSR_IDX_W = 1;

   // Integrator holds 0 .. MAX_DRIVE << FRAC_BITS inclusive
   localparam int INTEG_TOP = MAX_DRIVE * (2 ** FRAC_BITS);
   localparam int INTEG_W   = $clog2(INTEG_TOP + 1);
   localparam int DRIVE_W   = INTEG_W - FRAC_BITS;
   // Error term is ADC_W+1 signed bits, scaled by the gain
   localparam int ERR_W     = ADC_W + 1;
   localparam int SUM_W     = ((INTEG_W > ERR_W + GAIN_SHIFT) ?
                               INTEG_W : ERR_W + GAIN_SHIFT) + 2;

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURRENT_SETPOINT = 1'b0,
      CSR_VOLTAGE_CUTOFF   = 1'b1
   } csr_index_type;

   // Register file contents
   typedef struct packed {
      logic [ADC_W-1:0] current_setpoint;
      logic [ADC_W-1:0] voltage_cutoff;
   } csr_type;

   // One input item
   typedef struct packed {
      logic             func;
      logic             enable_request;
      logic [ADC_W-1:0] vout_sample;
      logic [ADC_W-1:0] ismps_sample;
   } req_item_type;

   // One result item
   typedef struct packed {
      logic [DUTY_W-1:0] buck_duty;
      logic              buck_full_on;
      logic [DUTY_W-1:0] boost_duty;
      logic              output_on;
      logic              tripped;
   } rsp_item_type;

   // Item function codes
   localparam logic FUNC_SAMPLE  = 1'b0;
   localparam logic FUNC_COMMAND = 1'b1;

endpackage

@@ rtl/sicr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sicr_req_if / sicr_rsp_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface sicr_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic                       enable_request;
   logic [sicr_pkg::ADC_W-1:0] vout_sample;
   logic [sicr_pkg::ADC_W-1:0] ismps_sample;

   modport source (output valid, func, enable_request, vout_sample, ismps_sample,
                   input ready);
   modport sink (input valid, func, enable_request, vout_sample, ismps_sample,
                 output ready);
endinterface

interface sicr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sicr_pkg::DUTY_W-1:0] buck_duty;
   logic                        buck_full_on;
   logic [sicr_pkg::DUTY_W-1:0] boost_duty;
   logic                        output_on;
   logic                        tripped;

   modport source (output valid, buck_duty, buck_full_on, boost_duty, output_on,
                   tripped, input ready);
   modport sink (input valid, buck_duty, buck_full_on, boost_duty, output_on,
                 tripped, output ready);
endinterface

@@ rtl/sicr_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sicr_csr
// Configuration registers: current setpoint and overvoltage cutoff.
// ----------------------------------------------------------------------------
module sicr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [sicr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sicr_pkg::ADC_W-1:0]     csr_wdata,
   output sicr_pkg::csr_type              csr
);

   sicr_pkg::csr_type csr_ff;
   sicr_pkg::csr_type csr_in;

   // Write decode
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (sicr_pkg::csr_index_type'(csr_index))
            sicr_pkg::CSR_CURRENT_SETPOINT: csr_in.current_setpoint = csr_wdata;
            sicr_pkg::CSR_VOLTAGE_CUTOFF:   csr_in.voltage_cutoff   = csr_wdata;
            default:                        csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

@@ rtl/sicr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sicr_core
// Regulator state (integrator, enable) and the per-item update: trip check,
// clamped integration and the split of the drive into buck/boost duties.
// ----------------------------------------------------------------------------
module sicr_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  sicr_pkg::req_item_type item,
   input  sicr_pkg::csr_type      csr,
   output sicr_pkg::rsp_item_type result
);

   localparam logic signed [sicr_pkg::SUM_W-1:0] TOP_S =
      sicr_pkg::SUM_W'(sicr_pkg::INTEG_TOP);
   localparam logic [sicr_pkg::DRIVE_W-1:0] PERIOD_D =
      sicr_pkg::DRIVE_W'(sicr_pkg::PWM_PERIOD);

   logic [sicr_pkg::INTEG_W-1:0]        integ_ff, integ_in;
   logic                                regulating_ff, regulating_in;

   logic signed [sicr_pkg::ERR_W-1:0]   err;
   logic signed [sicr_pkg::SUM_W-1:0]   delta;
   logic signed [sicr_pkg::SUM_W-1:0]   sum;
   logic [sicr_pkg::INTEG_W-1:0]        integ_clamped;
   logic [sicr_pkg::DRIVE_W-1:0]        drive;

   // Integrate gain * (setpoint - current), clamp to 0..top
   always_comb begin
      err   = $signed({1'b0, csr.current_setpoint}) - $signed({1'b0, item.ismps_sample});
      delta = sicr_pkg::SUM_W'(err) <<< sicr_pkg::GAIN_SHIFT;
      sum   = $signed({{(sicr_pkg::SUM_W - sicr_pkg::INTEG_W){1'b0}}, integ_ff}) + delta;
      if (sum[sicr_pkg::SUM_W-1]) begin
         integ_clamped = '0;
      end else if (sum > TOP_S) begin
         integ_clamped = sicr_pkg::INTEG_W'(sicr_pkg::INTEG_TOP);
      end else begin
         integ_clamped = sum[sicr_pkg::INTEG_W-1:0];
      end
      drive = integ_clamped[sicr_pkg::INTEG_W-1:sicr_pkg::FRAC_BITS];
   end

   // Item decode: command, idle sample, trip or regulation
   always_comb begin
      integ_in      = integ_ff;
      regulating_in = regulating_ff;
      result        = '0;
      if (item.func == sicr_pkg::FUNC_COMMAND) begin
         integ_in         = '0;
         regulating_in    = item.enable_request;
         result.output_on = item.enable_request;
      end else if (!regulating_ff) begin
         result = '0;
      end else if (item.vout_sample > csr.voltage_cutoff) begin
         integ_in       = '0;
         regulating_in  = 1'b0;
         result.tripped = 1'b1;
      end else begin
         integ_in         = integ_clamped;
         result.output_on = 1'b1;
         if (drive <= PERIOD_D) begin
            result.buck_duty = sicr_pkg::DUTY_W'(drive);
         end else begin
            // buck held on, excess drive goes to the boost switch
            result.buck_duty    = sicr_pkg::DUTY_W'(sicr_pkg::PWM_PERIOD);
            result.buck_full_on = 1'b1;
            result.boost_duty   = sicr_pkg::DUTY_W'(drive - PERIOD_D);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff      <= '0;
         regulating_ff <= 1'b0;
      end else if (step) begin
         integ_ff      <= integ_in;
         regulating_ff <= regulating_in;
      end
   end

endmodule

@@ rtl/smps_integral_current_regulator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smps_integral_current_regulator_unit
// Integral-only current regulator for a buck-boost charger.
// ----------------------------------------------------------------------------
// Each item passes an input register and then the regulator update into the
// result register, where its result waits for the result handshake. One item
// is taken every cycle while the result side keeps up. The integrator and
// enable state update as the item leaves the input register, so consecutive
// items always see the state left by the one before. Each item yields exactly
// one result; a stalled result holds both stages in place. Setpoint and cutoff
// are raw ADC counts; the user must write them only while no item is in
// flight, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module smps_integral_current_regulator_unit (
   input  logic                           clock,
   input  logic                           reset,
   sicr_req_if.sink                       req,
   sicr_rsp_if.source                     rsp,
   input  logic                           csr_wr_en,
   input  logic [sicr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sicr_pkg::ADC_W-1:0]     csr_wdata
);

   sicr_pkg::csr_type      csr;
   sicr_pkg::req_item_type req_item;
   sicr_pkg::req_item_type s1_item_ff;
   logic                   s1_valid_ff, s1_valid_in;
   sicr_pkg::rsp_item_type core_result;
   sicr_pkg::rsp_item_type rsp_item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;
   logic                   advance;
   logic                   accept;

   sicr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   // Handshake: result register frees up when empty or being taken
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || out_free;
   assign accept    = req.valid && req.ready;

   assign req_item.func           = req.func;
   assign req_item.enable_request = req.enable_request;
   assign req_item.vout_sample    = req.vout_sample;
   assign req_item.ismps_sample   = req.ismps_sample;

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !out_free);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp.ready);
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
   end

   sicr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_item_ff),
      .csr    (csr),
      .result (core_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.buck_duty    = rsp_item_ff.buck_duty;
   assign rsp.buck_full_on = rsp_item_ff.buck_full_on;
   assign rsp.boost_duty   = rsp_item_ff.boost_duty;
   assign rsp.output_on    = rsp_item_ff.output_on;
   assign rsp.tripped      = rsp_item_ff.tripped;

endmodule

@@ bench/smps_integral_current_regulator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smps_integral_current_regulator_unit_tb
// Self-checking bench for the integral current regulator. A scoreboard class
// tracks setpoint, cutoff, integrator and enable state and predicts the PWM
// result of every accepted item. Directed items cover on/off commands,
// samples while off, the overvoltage trip, the clamps and the buck/boost
// boundary. Random blocks follow under several register settings and
// sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module smps_integral_current_regulator_unit_tb;
   import sicr_pkg::*;

   localparam int GAIN = 4;

   // Scoreboard: PWM prediction and result checking
   class regulator_scoreboard;
      logic [ADC_W-1:0] setpoint;
      logic [ADC_W-1:0] cutoff;
      longint           integ;
      bit               running;
      rsp_item_type     expected_pwm[$];
      int               mismatches;

      function new();
         setpoint    = '0;
         cutoff      = '0;
         integ       = 0;
         running     = 1'b0;
         mismatches  = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [ADC_W-1:0] value);
         if (idx == CSR_CURRENT_SETPOINT)
            setpoint = value;
         else
            cutoff = value;
      endfunction

      // Work out the result of one accepted item and queue it
      function void note_item(req_item_type item);
         rsp_item_type pwm;
         longint       drive;
         pwm = '0;
         if (item.func == FUNC_COMMAND) begin
            integ         = 0;
            running       = item.enable_request;
            pwm.output_on = running;
         end else if (!running) begin
            // off: all fields stay zero
         end else if (item.vout_sample > cutoff) begin
            integ       = 0;
            running     = 1'b0;
            pwm.tripped = 1'b1;
         end else begin
            integ = integ + GAIN * (longint'(setpoint) - longint'(item.ismps_sample));
            if (integ < 0)
               integ = 0;
            if (integ > INTEG_TOP)
               integ = INTEG_TOP;
            drive = integ >>> FRAC_BITS;
            if (drive > MAX_DRIVE)
               drive = MAX_DRIVE;
            pwm.output_on = 1'b1;
            if (drive <= PWM_PERIOD) begin
               pwm.buck_duty = DUTY_W'(drive);
            end else begin
               pwm.buck_duty    = DUTY_W'(PWM_PERIOD);
               pwm.buck_full_on = 1'b1;
               pwm.boost_duty   = DUTY_W'(drive - PWM_PERIOD);
            end
         end
         expected_pwm.push_back(pwm);
      endfunction

      // Compare one result with the oldest expectation
      function void check_result(rsp_item_type got);
         rsp_item_type want;
         bit           bad;
         if (expected_pwm.size() == 0) begin
            if (mismatches < 10)
               $display({"%0t: result with nothing expected: ",
                         "buck=%0d full=%0b boost=%0d on=%0b trip=%0b"},
                        $realtime, got.buck_duty, got.buck_full_on, got.boost_duty,
                        got.output_on, got.tripped);
            mismatches++;
            return;
         end
         want = expected_pwm.pop_front();
         bad  = (got.buck_duty !== want.buck_duty) ||
                (got.buck_full_on !== want.buck_full_on) ||
                (got.boost_duty !== want.boost_duty) ||
                (got.output_on !== want.output_on) ||
                (got.tripped !== want.tripped);
         if (bad) begin
            if (mismatches < 10)
               $display({"%0t: mismatch exp buck=%0d full=%0b boost=%0d on=%0b trip=%0b, ",
                         "got buck=%0d full=%0b boost=%0d on=%0b trip=%0b"},
                        $realtime, want.buck_duty, want.buck_full_on, want.boost_duty,
                        want.output_on, want.tripped, got.buck_duty, got.buck_full_on,
                        got.boost_duty, got.output_on, got.tripped);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADC_W-1:0]   csr_wdata;

   int                 send_idle_pct;
   int                 sink_stall_pct;
   regulator_scoreboard ledger;

   int                 idle_tab[4]  = '{0, 71, 0, 11};
   int                 stall_tab[4] = '{0, 0, 71, 11};

   sicr_req_if req_ch ();
   sicr_rsp_if rsp_ch ();

   smps_integral_current_regulator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Result side stalls at random
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // Check every accepted result
   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.buck_duty    = rsp_ch.buck_duty;
         got.buck_full_on = rsp_ch.buck_full_on;
         got.boost_duty   = rsp_ch.boost_duty;
         got.output_on    = rsp_ch.output_on;
         got.tripped      = rsp_ch.tripped;
         ledger.check_result(got);
      end
   end

   // Offer one item, with random idle cycles, and note it once accepted
   task automatic send_item(input req_item_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.func           <= item.func;
      req_ch.enable_request <= item.enable_request;
      req_ch.vout_sample    <= item.vout_sample;
      req_ch.ismps_sample   <= item.ismps_sample;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      ledger.note_item(item);
   endtask

   task automatic send_fields(input logic func, input logic en,
                              input logic [ADC_W-1:0] vout,
                              input logic [ADC_W-1:0] ismps);
      req_item_type item;
      item.func           = func;
      item.enable_request = en;
      item.vout_sample    = vout;
      item.ismps_sample   = ismps;
      send_item(item);
   endtask

   // Stop sending and wait for every outstanding result, then let the
   // pipeline settle
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (ledger.expected_pwm.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [ADC_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      ledger.write_register(idx, value);
   endtask

   task automatic apply_settings(input logic [ADC_W-1:0] sp, input logic [ADC_W-1:0] co);
      drain_results();
      write_register(CSR_CURRENT_SETPOINT, sp);
      write_register(CSR_VOLTAGE_CUTOFF, co);
   endtask

   // Mostly in-range samples near the setpoint with a per-block drift,
   // plus commands, overvoltage and full-range noise
   function automatic req_item_type random_item(input logic [ADC_W-1:0] sp,
                                                input logic [ADC_W-1:0] co,
                                                input int bias);
      req_item_type item;
      int           near;
      item.func           = FUNC_SAMPLE;
      item.enable_request = 1'($urandom_range(1));
      if ($urandom_range(99) < 8) begin
         item.func           = FUNC_COMMAND;
         item.enable_request = ($urandom_range(9) != 0);
      end
      if ($urandom_range(19) == 0)
         item.vout_sample = ADC_W'($urandom);
      else
         item.vout_sample = ADC_W'($urandom_range(co, 0));
      case ($urandom_range(4))
         0, 1, 2: begin
            near = int'(sp) - bias + int'($urandom_range(1000)) - 500;
            if (near < 0)
               near = 0;
            if (near > 65535)
               near = 65535;
            item.ismps_sample = ADC_W'(near);
         end
         3: item.ismps_sample = ADC_W'($urandom);
         default: item.ismps_sample = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
      return item;
   endfunction

   // Stimulus
   initial begin
      logic [ADC_W-1:0] sp;
      logic [ADC_W-1:0] co;
      int               bias;

      ledger                = new();
      req_ch.valid          = 1'b0;
      req_ch.func           = FUNC_SAMPLE;
      req_ch.enable_request = 1'b0;
      req_ch.vout_sample    = '0;
      req_ch.ismps_sample   = '0;
      rsp_ch.ready          = 1'b0;
      csr_wr_en             = 1'b0;
      csr_index             = CSR_CURRENT_SETPOINT;
      csr_wdata             = '0;
      send_idle_pct         = 0;
      sink_stall_pct        = 0;
      reset                 = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full-scale setpoint: sample while off, boost, top clamp, switch off
      apply_settings(16'hFFFF, 16'hFFFF);
      send_fields(FUNC_SAMPLE, 1'b1, 16'hFFFF, 16'h0000);
      send_fields(FUNC_COMMAND, 1'b1, 16'hFFFF, 16'hFFFF);
      send_fields(FUNC_SAMPLE, 1'b0, 16'h0000, 16'h0000);
      send_fields(FUNC_SAMPLE, 1'b0, 16'hFFFF, 16'h0000);
      send_fields(FUNC_SAMPLE, 1'b1, 16'h1234, 16'hFFFF);
      send_fields(FUNC_COMMAND, 1'b0, 16'h0000, 16'h0000);
      send_fields(FUNC_SAMPLE, 1'b0, 16'h0000, 16'h0000);

      // Zero setpoint and cutoff: bottom clamp, trip, sample after trip
      apply_settings(16'h0000, 16'h0000);
      send_fields(FUNC_COMMAND, 1'b1, 16'hA5A5, 16'h5A5A);
      send_fields(FUNC_SAMPLE, 1'b0, 16'h0000, 16'hFFFF);
      send_fields(FUNC_SAMPLE, 1'b1, 16'h0000, 16'h0000);
      send_fields(FUNC_SAMPLE, 1'b0, 16'h0001, 16'h0000);
      send_fields(FUNC_SAMPLE, 1'b0, 16'h0000, 16'h0000);
      send_fields(FUNC_COMMAND, 1'b1, 16'h0000, 16'h0000);
      send_fields(FUNC_COMMAND, 1'b1, 16'hFFFF, 16'hFFFF);
      send_fields(FUNC_COMMAND, 1'b0, 16'hFFFF, 16'h0000);

      // Buck/boost boundary: drive of exactly one period, then one above, then a trip
      apply_settings(16'h8000, 16'd30000);
      send_fields(FUNC_COMMAND, 1'b1, 16'h0000, 16'h0000);
      send_fields(FUNC_SAMPLE, 1'b0, 16'd30000, 16'h0000);
      send_fields(FUNC_SAMPLE, 1'b0, 16'd100, 16'd32704);
      send_fields(FUNC_SAMPLE, 1'b0, 16'd30001, 16'h0000);

      // Random blocks under each idling mix, new settings per block
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_tab[ph];
         sink_stall_pct = stall_tab[ph];
         for (int blk = 0; blk < 4; blk++) begin
            case ($urandom_range(5))
               0: sp = 16'h0000;
               1: sp = 16'hFFFF;
               default: sp = ADC_W'($urandom);
            endcase
            case ($urandom_range(5))
               0: co = 16'h0000;
               1: co = 16'hFFFF;
               default: co = ADC_W'($urandom_range(65535, 8000));
            endcase
            bias = int'($urandom_range(5000)) - 2000;
            apply_settings(sp, co);
            repeat (25)
               send_item(random_item(sp, co, bias));
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.expected_pwm.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/sicr_pkg.sv
rtl/sicr_if.sv
rtl/sicr_csr.sv
rtl/sicr_core.sv
rtl/smps_integral_current_regulator_unit.sv
bench/smps_integral_current_regulator_unit_tb.sv
